@@ sv/sfg_pkg.sv @@
package sfg_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAX_SCALE  = 8;
	localparam int SCALE_W    = 4;
	localparam int SUB_W      = $clog2(MAX_SCALE);
	localparam int FONT_ROWS  = 7;
	localparam int FONT_COLS  = 5;
	localparam int ROW_W      = FONT_COLS * MAX_SCALE;
	localparam int GLYPH_W    = 6;
	localparam int FROW_W     = 3;
	localparam int STEP_W     = 6;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 6'd36;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_SCALE   = 2'd2;

	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       new_string;
	} item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] row_x;
		logic [COORD_BITS-1:0] row_y;
		logic [ROW_W-1:0]      row_bits;
		logic                  last_row;
	} row_t;

	typedef struct packed {
		logic                  go;
		logic [GLYPH_W-1:0]    glyph;
		logic [COORD_BITS-1:0] y;
		logic [SCALE_W-1:0]    scale;
	} start_t;

	typedef struct packed {
		logic                  busy;
		logic                  fire;
		logic                  last;
		logic [FROW_W-1:0]     font_row;
		logic [COORD_BITS-1:0] y;
		logic [GLYPH_W-1:0]    glyph;
		logic [SCALE_W-1:0]    scale;
	} ctrl_t;

	function automatic logic [FONT_COLS*FONT_ROWS-1:0] pack5(
		input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
		input logic [7:0] c3, input logic [7:0] c4);
		return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
	endfunction

	// Column font: column c in bits [7c+6:7c], font row r at bit r of a column.
	function automatic logic [FONT_COLS*FONT_ROWS-1:0] font_cols(input logic [GLYPH_W-1:0] g);
		logic [FONT_COLS*FONT_ROWS-1:0] f;
		case (g)
			6'd0:  f = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
			6'd1:  f = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
			6'd2:  f = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
			6'd3:  f = pack5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
			6'd4:  f = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
			6'd5:  f = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
			6'd6:  f = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
			6'd7:  f = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
			6'd8:  f = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
			6'd9:  f = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
			6'd10: f = pack5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
			6'd11: f = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
			6'd12: f = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
			6'd13: f = pack5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
			6'd14: f = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
			6'd15: f = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
			6'd16: f = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
			6'd17: f = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
			6'd18: f = pack5(8'h41, 8'h7F, 8'h41, 8'h00, 8'h00);
			6'd19: f = pack5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
			6'd20: f = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
			6'd21: f = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
			6'd22: f = pack5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
			6'd23: f = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
			6'd24: f = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
			6'd25: f = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
			6'd26: f = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
			6'd27: f = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
			6'd28: f = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
			6'd29: f = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
			6'd30: f = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
			6'd31: f = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
			6'd32: f = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
			6'd33: f = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
			6'd34: f = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
			6'd35: f = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
			default: f = '0;
		endcase
		return f;
	endfunction

	// Returns {supported, glyph index}; lower case folds onto upper case.
	function automatic logic [GLYPH_W:0] lookup_glyph(input logic [7:0] code);
		logic [GLYPH_W:0] r;
		if (code >= CH_UA && code <= CH_UZ) begin
			r = {1'b1, GLYPH_W'(code - CH_UA) + 6'd10};
		end else if (code >= CH_LA && code <= CH_LZ) begin
			r = {1'b1, GLYPH_W'(code - CH_LA) + 6'd10};
		end else if (code >= CH_ZERO && code <= CH_NINE) begin
			r = {1'b1, GLYPH_W'(code - CH_ZERO)};
		end else if (code == CH_SPACE) begin
			r = {1'b1, SPACE_GLYPH};
		end else begin
			r = '0;
		end
		return r;
	endfunction

	// Clamp scale into 1..MAX_SCALE.
	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
		logic [SCALE_W-1:0] r;
		if (s == '0) begin
			r = SCALE_W'(1);
		end else if (s > SCALE_W'(MAX_SCALE)) begin
			r = SCALE_W'(MAX_SCALE);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

@@ sv/scaled_font_glyph_rasterizer.sv @@
// Once a character is taken the sequencer enters its emit state, and the first row is loaded
// into the output register when it is free. Throughput: one scaled row per cycle while the
// sink does not stall, 7*scale rows per glyph; an unsupported code only moves the pen.
// The rate is set by the single row unit, which builds one row bitmap per cycle.
// Reset: sequencer idle, output empty, pen_x = 0, start_x = 0, start_y = 0, scale = 1.
module scaled_font_glyph_rasterizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  sfg_pkg::item_t              item,
	output logic                        row_valid,
	input  logic                        row_stall,
	output sfg_pkg::row_t               row,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfg_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfg_pkg::DATA_W-1:0]  pwdata,
	output logic [sfg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import sfg_pkg::*;

	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [COORD_BITS-1:0] pen_q;
	logic [COORD_BITS-1:0] row_x_q;
	logic                  row_valid_q;
	row_t                  row_q;

	logic                  accept;
	logic                  cfg_wr;
	logic [SCALE_W-1:0]    scale_eff;
	logic [STEP_W-1:0]     advance;
	logic [COORD_BITS-1:0] pen_base;
	logic [COORD_BITS:0]   pen_sum;
	logic [GLYPH_W:0]      lookup;
	logic                  row_free;
	logic [ROW_W-1:0]      bits;
	start_t                start;
	ctrl_t                 ctrl;

	// Configuration port: zero-wait APB, register index in paddr[3:2].
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			scale_q   <= SCALE_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_START_X: start_x_q <= pwdata[COORD_BITS-1:0];
				REG_START_Y: start_y_q <= pwdata[COORD_BITS-1:0];
				REG_SCALE:   scale_q   <= pwdata[SCALE_W-1:0];
				default:     ; // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_X: prdata = DATA_W'(start_x_q);
			REG_START_Y: prdata = DATA_W'(start_y_q);
			REG_SCALE:   prdata = DATA_W'(scale_q);
			default:     prdata = '0;
		endcase
	end

	// Hold the input while the sequencer walks a glyph.
	assign item_stall = ctrl.busy;
	assign accept     = item_valid && !item_stall;

	// Pen handling happens at accept time: latch the x for this character,
	// then advance by 6*scale with saturation, whether or not a glyph exists.
	assign scale_eff = clamp_scale(scale_q);
	assign advance   = STEP_W'(scale_eff) * STEP_W'(6);
	assign pen_base  = item.new_string ? start_x_q : pen_q;
	assign pen_sum   = {1'b0, pen_base} + (COORD_BITS + 1)'(advance);
	assign lookup    = lookup_glyph(item.char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= '0;
		end else if (accept) begin
			pen_q <= pen_sum[COORD_BITS] ? '1 : pen_sum[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) row_x_q <= pen_base;
	end

	// Start a row walk only for codes that have a glyph.
	always_comb begin
		start.go    = accept && lookup[GLYPH_W];
		start.glyph = lookup[GLYPH_W-1:0];
		start.y     = start_y_q;
		start.scale = scale_eff;
	end

	// Output register doubles as the skid stage toward the sink.
	assign row_free = !row_valid_q || !row_stall;

	sfg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.row_free (row_free),
		.ctrl     (ctrl)
	);

	sfg_row_unit u_row_unit (
		.glyph    (ctrl.glyph),
		.font_row (ctrl.font_row),
		.scale    (ctrl.scale),
		.bits     (bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
		end else if (ctrl.fire) begin
			row_valid_q <= 1'b1;
		end else if (!row_stall) begin
			row_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			row_q.row_x    <= row_x_q;
			row_q.row_y    <= ctrl.y;
			row_q.row_bits <= bits;
			row_q.last_row <= ctrl.last;
		end
	end

	assign row_valid = row_valid_q;
	assign row       = row_q;

`ifndef SYNTHESIS
	// Release the input right after the final row of a glyph is loaded.
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire && ctrl.last |=> !item_stall)
		else $error("input still stalled after final row");

	// Stay busy between rows of one glyph.
	a_busy_mid_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire && !ctrl.last |=> item_stall)
		else $error("input released in the middle of a glyph");

	// No pixel beyond 5*scale on a loaded row.
	a_bits_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire |-> ((bits >> (FONT_COLS * int'(ctrl.scale))) == '0))
		else $error("row bitmap wider than 5*scale");
`endif

endmodule

@@ sv/sfg_row_unit.sv @@
module sfg_row_unit (
	input  logic [sfg_pkg::GLYPH_W-1:0] glyph,
	input  logic [sfg_pkg::FROW_W-1:0]  font_row,
	input  logic [sfg_pkg::SCALE_W-1:0] scale,
	output logic [sfg_pkg::ROW_W-1:0]   bits
);
	import sfg_pkg::*;

	logic [FONT_COLS*FONT_ROWS-1:0] cols;

	assign cols = font_cols(glyph);

	// Replicate each lit font pixel scale times, columns packed side by side.
	always_comb begin
		logic [5:0] pos;
		logic       lit;
		bits = '0;
		for (int c = 0; c < FONT_COLS; c++) begin
			lit = cols[c*FONT_ROWS + int'(font_row)];
			for (int b = 0; b < MAX_SCALE; b++) begin
				pos = 6'(c * int'(scale) + b);
				if (b < int'(scale) && pos < 6'(ROW_W)) begin
					bits[pos] = lit;
				end
			end
		end
	end

endmodule

@@ sv/sfg_seq.sv @@
module sfg_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  sfg_pkg::start_t start,
	input  logic            row_free,
	output sfg_pkg::ctrl_t  ctrl
);
	import sfg_pkg::*;

	state_t                state_q, state_d;
	logic [GLYPH_W-1:0]    glyph_q;
	logic [FROW_W-1:0]     font_row_q;
	logic [SUB_W-1:0]      sub_q;
	logic [COORD_BITS-1:0] y_q;
	logic [SCALE_W-1:0]    scale_q;
	logic                  sub_end;

	assign sub_end = (sub_q == SUB_W'(scale_q - SCALE_W'(1)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start.go) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (ctrl.fire && ctrl.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.font_row = font_row_q;
		ctrl.y        = y_q;
		ctrl.glyph    = glyph_q;
		ctrl.scale    = scale_q;
		case (state_q)
			ST_IDLE: begin
				ctrl.busy = 1'b0;
			end
			ST_EMIT: begin
				ctrl.busy = 1'b1;
				ctrl.fire = row_free;
				ctrl.last = sub_end && (font_row_q == FROW_W'(FONT_ROWS - 1));
			end
			default: ctrl.busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row walk: sub-row inside a font row, then font row; y saturates.
	always_ff @(posedge clk) begin
		if (start.go) begin
			glyph_q    <= start.glyph;
			scale_q    <= start.scale;
			y_q        <= start.y;
			font_row_q <= '0;
			sub_q      <= '0;
		end else if (ctrl.fire) begin
			if (sub_end) begin
				sub_q      <= '0;
				font_row_q <= font_row_q + FROW_W'(1);
			end else begin
				sub_q <= sub_q + SUB_W'(1);
			end
			if (!(&y_q)) y_q <= y_q + COORD_BITS'(1);
		end
	end

endmodule

@@ tb/glyph_row_monitor.sv @@
`timescale 1ns / 100ps

module glyph_row_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  sfg_pkg::item_t              item,
	input  logic                        row_valid,
	input  logic                        row_stall,
	input  sfg_pkg::row_t               row,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfg_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfg_pkg::DATA_W-1:0]  pwdata,
	input  logic                        pready,
	output int                          rows_due,
	output int                          bad_rows
);

	import sfg_pkg::*;

	localparam int COORD_LIMIT = (1 << COORD_BITS) - 1;

	logic [COORD_BITS-1:0] origin_x;
	logic [COORD_BITS-1:0] line_y;
	logic [COORD_BITS-1:0] pen_x;
	logic [SCALE_W-1:0]    scale_reg;
	row_t                  rows_pending[$];

	// Leftmost column in the top byte; font row r sits at bit r of a column.
	function automatic logic [39:0] glyph_columns(input int g);
		logic [39:0] v;
		case (g)
			0:  v = 40'h3E_51_49_45_3E;
			1:  v = 40'h00_42_7F_40_00;
			2:  v = 40'h42_61_51_49_46;
			3:  v = 40'h21_41_45_4B_31;
			4:  v = 40'h18_14_12_7F_10;
			5:  v = 40'h27_45_45_45_39;
			6:  v = 40'h3C_4A_49_49_30;
			7:  v = 40'h01_71_09_05_03;
			8:  v = 40'h36_49_49_49_36;
			9:  v = 40'h06_49_49_29_1E;
			10: v = 40'h7E_11_11_11_7E;
			11: v = 40'h7F_49_49_49_36;
			12: v = 40'h3E_41_41_41_22;
			13: v = 40'h7F_41_41_22_1C;
			14: v = 40'h7F_49_49_49_41;
			15: v = 40'h7F_09_09_09_01;
			16: v = 40'h3E_41_49_49_3A;
			17: v = 40'h7F_08_08_08_7F;
			18: v = 40'h41_7F_41_00_00;
			19: v = 40'h20_40_41_3F_01;
			20: v = 40'h7F_08_14_22_41;
			21: v = 40'h7F_40_40_40_40;
			22: v = 40'h7F_02_0C_02_7F;
			23: v = 40'h7F_04_08_10_7F;
			24: v = 40'h3E_41_41_41_3E;
			25: v = 40'h7F_09_09_09_06;
			26: v = 40'h3E_41_51_21_5E;
			27: v = 40'h7F_09_19_29_46;
			28: v = 40'h46_49_49_49_31;
			29: v = 40'h01_01_7F_01_01;
			30: v = 40'h3F_40_40_40_3F;
			31: v = 40'h1F_20_40_20_1F;
			32: v = 40'h3F_40_38_40_3F;
			33: v = 40'h63_14_08_14_63;
			34: v = 40'h07_08_70_08_07;
			35: v = 40'h61_51_49_45_43;
			default: v = '0;
		endcase
		return v;
	endfunction

	// -1 marks a code with no glyph.
	function automatic int glyph_of(input logic [7:0] code);
		int g;
		if (code >= CH_UA && code <= CH_UZ) begin
			g = int'(code - CH_UA) + 10;
		end else if (code >= CH_LA && code <= CH_LZ) begin
			g = int'(code - CH_LA) + 10;
		end else if (code >= CH_ZERO && code <= CH_NINE) begin
			g = int'(code - CH_ZERO);
		end else if (code == CH_SPACE) begin
			g = int'(SPACE_GLYPH);
		end else begin
			g = -1;
		end
		return g;
	endfunction

	task automatic render_char(input logic [7:0] code, input logic restart);
		int          s;
		int          g;
		int          r;
		int          c;
		int          y;
		int          next_x;
		logic [39:0] cols;
		logic [7:0]  column;
		row_t        rr;
		if (scale_reg == '0) begin
			s = 1;
		end else if (scale_reg > MAX_SCALE) begin
			s = MAX_SCALE;
		end else begin
			s = int'(scale_reg);
		end
		if (restart) begin
			pen_x = origin_x;
		end
		g = glyph_of(code);
		if (g >= 0) begin
			cols = glyph_columns(g);
			for (r = 0; r < FONT_ROWS * s; r++) begin
				y = int'(line_y) + r;
				rr.row_x    = pen_x;
				rr.row_y    = (y > COORD_LIMIT) ? COORD_BITS'(COORD_LIMIT) : COORD_BITS'(y);
				rr.row_bits = '0;
				for (c = 0; c < FONT_COLS; c++) begin
					column = cols[8*(4-c) +: 8];
					if (column[r / s]) begin
						rr.row_bits = rr.row_bits | ((((ROW_W)'(1)) << s) - 1) << (c * s);
					end
				end
				rr.last_row = (r == FONT_ROWS * s - 1);
				rows_pending.push_back(rr);
			end
		end
		next_x = int'(pen_x) + 6 * s;
		pen_x = (next_x > COORD_LIMIT) ? COORD_BITS'(COORD_LIMIT) : COORD_BITS'(next_x);
	endtask

	task automatic check_row(input row_t got);
		row_t want;
		if (rows_pending.size() == 0) begin
			if (bad_rows < 10) begin
				$display("%0t: unexpected row x=%h y=%h bits=%h last=%b", $realtime,
					got.row_x, got.row_y, got.row_bits, got.last_row);
			end
			bad_rows++;
		end else begin
			want = rows_pending.pop_front();
			if (got.row_x !== want.row_x || got.row_y !== want.row_y ||
				got.row_bits !== want.row_bits || got.last_row !== want.last_row) begin
				if (bad_rows < 10) begin
					$display("%0t: row mismatch x=%h/%h y=%h/%h bits=%h/%h last=%b/%b (want/got)",
						$realtime, want.row_x, got.row_x, want.row_y, got.row_y,
						want.row_bits, got.row_bits, want.last_row, got.last_row);
				end
				bad_rows++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x  = '0;
			line_y    = '0;
			scale_reg = SCALE_W'(1);
			pen_x     = '0;
			rows_pending.delete();
			rows_due  = 0;
			bad_rows  = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_START_X: origin_x  = pwdata[COORD_BITS-1:0];
					REG_START_Y: line_y    = pwdata[COORD_BITS-1:0];
					REG_SCALE:   scale_reg = pwdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				render_char(item.char_code, item.new_string);
			end
			if (row_valid && !row_stall) begin
				check_row(row);
			end
			rows_due = rows_pending.size();
		end
	end

endmodule

@@ tb/tb_scaled_font_glyph_rasterizer.sv @@
`timescale 1ns / 100ps

module tb_scaled_font_glyph_rasterizer;

	import sfg_pkg::*;

	// Address slot past the register list; writes there must be dropped.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Cycles to let pass after the last row before touching registers or ending:
	// covers the sequencer and output register and an unsupported code still moving the pen.
	localparam int SETTLE_CYCLES = 8;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item       = '0;
	logic               row_valid;
	logic               row_stall  = 1'b0;
	row_t               row;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [ADDR_W-1:0]  paddr      = '0;
	logic [DATA_W-1:0]  pwdata     = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int                 rows_due;
	int                 bad_rows;

	// Set for phases where neither side idles at all.
	bit                 quiet = 1'b0;

	always #1 clk = ~clk;

	scaled_font_glyph_rasterizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.row_valid  (row_valid),
		.row_stall  (row_stall),
		.row        (row),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	glyph_row_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.row_valid  (row_valid),
		.row_stall  (row_stall),
		.row        (row),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.rows_due   (rows_due),
		.bad_rows   (bad_rows)
	);

	// Setup cycle, then access cycle; the register takes the value at the edge
	// that closes the access cycle. End on an idle negedge so that back-to-back
	// writes never drive psel twice in one step.
	task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid, wait for every predicted row to drain, then let the pipeline
	// run dry. Called at a negedge, where the monitor's count is stable.
	task automatic settle();
		item_valid <= 1'b0;
		while (rows_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offer one character after a random gap and hold it until the block takes it.
	// Entered and left at a negedge.
	task automatic send_char(input logic [7:0] code, input logic restart);
		int    gap;
		item_t next_item;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		next_item.char_code  = code;
		next_item.new_string = restart;
		item       <= next_item;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly printable glyphs with random content; the rest is any byte at all.
	function automatic logic [7:0] pick_char();
		int sel;
		logic [7:0] code;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			code = CH_UA + 8'($urandom_range(0, 25));
		end else if (sel < 50) begin
			code = CH_LA + 8'($urandom_range(0, 25));
		end else if (sel < 65) begin
			code = CH_ZERO + 8'($urandom_range(0, 9));
		end else if (sel < 75) begin
			code = CH_SPACE;
		end else begin
			code = 8'($urandom_range(0, 255));
		end
		return code;
	endfunction

	// Keep most glyphs small so the run stays short; hit the clamps now and then.
	function automatic logic [SCALE_W-1:0] pick_scale();
		int sel;
		logic [SCALE_W-1:0] s;
		sel = $urandom_range(0, 9);
		case (sel)
			6:       s = SCALE_W'($urandom_range(3, 4));
			7:       s = SCALE_W'(MAX_SCALE);
			8:       s = '0;
			9:       s = SCALE_W'($urandom_range(MAX_SCALE + 1, 15));
			default: s = SCALE_W'($urandom_range(1, 2));
		endcase
		return s;
	endfunction

	// Coordinates near the top of the range exercise saturation.
	function automatic logic [COORD_BITS-1:0] pick_coord();
		int sel;
		logic [COORD_BITS-1:0] v;
		sel = $urandom_range(0, 3);
		case (sel)
			0:       v = COORD_BITS'($urandom_range(0, 65535));
			1:       v = COORD_BITS'($urandom_range(16'hFF00, 16'hFFFF));
			default: v = COORD_BITS'($urandom_range(0, 1000));
		endcase
		return v;
	endfunction

	// Receiver: for every row draw a random stall (none in quiet phases), then accept.
	initial begin : row_sink
		int hold;
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				row_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			row_stall <= 1'b0;
			@(posedge clk);
			while (!row_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int i;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: scale 1, offset origin, upper register bits must be dropped.
		quiet = 1'b1;
		write_reg(REG_START_X, 32'hABCD_0064);
		write_reg(REG_START_Y, 32'h1234_00C8);
		write_reg(REG_SCALE, 32'hFFFF_FFF1);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_char(CH_ZERO, 1'b1);
		send_char(CH_UA, 1'b0);
		send_char(CH_LA, 1'b0);
		send_char(CH_UZ, 1'b0);
		send_char(CH_LZ, 1'b0);
		send_char(CH_NINE, 1'b0);
		send_char(CH_SPACE, 1'b0);
		// Codes with no glyph, including those next to each supported range.
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_ZERO - 8'd1, 1'b0);
		send_char(CH_NINE + 8'd1, 1'b0);
		send_char(CH_UA - 8'd1, 1'b0);
		send_char(CH_UZ + 8'd1, 1'b0);
		send_char(CH_LA - 8'd1, 1'b0);
		send_char(CH_LZ + 8'd1, 1'b0);

		// Zero scale behaves as one.
		settle();
		quiet = 1'b0;
		write_reg(REG_SCALE, 32'd0);
		send_char(CH_UA + 8'd12, 1'b1);

		// Largest scale near the coordinate limit: pen and row y saturate.
		settle();
		write_reg(REG_SCALE, 32'(MAX_SCALE));
		write_reg(REG_START_X, 32'h0000_FFF0);
		write_reg(REG_START_Y, 32'h0000_FFF0);
		send_char(CH_UA + 8'd22, 1'b1);
		send_char(CH_ZERO + 8'd8, 1'b0);
		send_char(CH_SPACE, 1'b0);

		// Scale above the limit clamps; origin at the very top of the range.
		settle();
		write_reg(REG_SCALE, 32'd15);
		write_reg(REG_START_X, 32'h0000_FFFF);
		write_reg(REG_START_Y, 32'h0000_FFFF);
		send_char(CH_UA + 8'd23, 1'b1);
		send_char(8'h7F, 1'b0);
		send_char(CH_LA + 8'd23, 1'b0);

		// Random phases: drain fully, retune the registers, then stream.
		for (i = 0; i < 150; i++) begin
			if (i % 30 == 0) begin
				settle();
				quiet = ($urandom_range(0, 3) == 0);
				write_reg(REG_START_X, ($urandom & 32'hFFFF_0000) | 32'(pick_coord()));
				write_reg(REG_START_Y, ($urandom & 32'hFFFF_0000) | 32'(pick_coord()));
				write_reg(REG_SCALE, ($urandom & 32'hFFFF_FFF0) | 32'(pick_scale()));
			end
			send_char(pick_char(), ($urandom_range(0, 7) == 0));
		end

		settle();
		if (bad_rows == 0 && rows_due == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
